>>> rtl/csra_pkg.sv
`timescale 1ns / 1ps

package csra_pkg;

	localparam int MAX_MESSAGE_BYTES_DEF = 1024;
	localparam int HEADER_BYTES          = 3;
	localparam logic [8:0] COUNT_MAX     = 9'd511;

	localparam logic [7:0] FIRST_MASK_RST = 8'd1;
	localparam logic [7:0] LAST_MASK_RST  = 8'd2;
	localparam logic [7:0] ABORT_MASK_RST = 8'd4;

	typedef enum logic [1:0] {
		CFG_FIRST_MASK = 2'd0,
		CFG_LAST_MASK  = 2'd1,
		CFG_ABORT_MASK = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_ABORT = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		LS_IDLE      = 2'd0,
		LS_RECEIVING = 2'd1,
		LS_APPLIED   = 2'd2,
		LS_ERROR     = 2'd3
	} link_t;

	typedef enum logic [2:0] {
		EC_OK        = 3'd0,
		EC_BAD_FRAME = 3'd1,
		EC_SEQ_GAP   = 3'd2,
		EC_NO_FIRST  = 3'd3,
		EC_TOO_LONG  = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		ATT_OK       = 2'd0,
		ATT_BAD_LEN  = 2'd1,
		ATT_UNLIKELY = 2'd2,
		ATT_NO_RES   = 2'd3
	} att_t;

	typedef struct packed {
		logic        has_result;
		att_t        att;
		link_t       link;
		err_t        code;
		logic        commit;
		logic [10:0] msg_len;
		logic [7:0]  fill_cnt;
		logic        rd_sel;
	} res_t;

endpackage

>>> rtl/csra_if.sv
`timescale 1ns / 1ps

interface csra_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic       end_of_write;
	logic [9:0] read_index;

	modport source (output valid, func, data_byte, end_of_write, read_index, input ready);
	modport sink   (input valid, func, data_byte, end_of_write, read_index, output ready);
endinterface

interface csra_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  att_result;
	logic [1:0]  link_state;
	logic [2:0]  error_code;
	logic        commit_ready;
	logic [10:0] message_length;
	logic [7:0]  fill_count;
	logic [7:0]  read_byte;

	modport source (output valid, att_result, link_state, error_code, commit_ready,
		message_length, fill_count, read_byte, input ready);
	modport sink   (input valid, att_result, link_state, error_code, commit_ready,
		message_length, fill_count, read_byte, output ready);
endinterface

>>> rtl/chunk_sequence_reassembler.sv
`timescale 1ns / 1ps

// Chunk reassembler: one byte item per cycle, each item passing an input
// register and then a result register; a new one is taken every cycle while
// the result side keeps up. Write bytes give a result only on the closing
// byte of a chunk; reads and abort commands always give one. Payload bytes
// go straight into a single-port-write store of MAX_MESSAGE_BYTES entries
// whose registered read port serves read requests; the store needs no
// clearing pass, and a read of a committed message must come before the
// next message's payload.

module chunk_sequence_reassembler #(
	parameter int MAX_MESSAGE_BYTES = csra_pkg::MAX_MESSAGE_BYTES_DEF,
	localparam int AW               = $clog2(MAX_MESSAGE_BYTES)
) (
	input  logic       clk,
	input  logic       arst_n,
	csra_in_if.sink    req,
	csra_out_if.source rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic              s1_v_q;
	csra_pkg::func_t   func_s1;
	logic [7:0]        data_s1;
	logic              eow_s1;
	logic [9:0]        ridx_s1;

	logic              s2_v_q;
	csra_pkg::res_t    res_s2;
	csra_pkg::res_t    res;

	logic              adv, fire;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;

	assign adv       = !s2_v_q || rsp.ready;
	assign fire      = s1_v_q && adv;
	assign req.ready = !s1_v_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (req.ready) begin
			s1_v_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= csra_pkg::func_t'(req.func);
			data_s1 <= req.data_byte;
			eow_s1  <= req.end_of_write;
			ridx_s1 <= req.read_index;
		end
	end

	csra_ctrl #(
		.MAX_BYTES (MAX_MESSAGE_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fire         (fire),
		.func         (func_s1),
		.data_byte    (data_s1),
		.end_of_write (eow_s1),
		.read_index   (ridx_s1),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.res          (res)
	);

	csra_store #(
		.DEPTH (MAX_MESSAGE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (adv) begin
			s2_v_q <= fire && res.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.has_result) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid          = s2_v_q;
	assign rsp.att_result     = res_s2.att;
	assign rsp.link_state     = res_s2.link;
	assign rsp.error_code     = res_s2.code;
	assign rsp.commit_ready   = res_s2.commit;
	assign rsp.message_length = res_s2.msg_len;
	assign rsp.fill_count     = res_s2.fill_cnt;
	assign rsp.read_byte      = res_s2.rd_sel ? mem_rdata : 8'd0;

	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && res_s2.commit |->
			res_s2.link == csra_pkg::LS_RECEIVING && res_s2.code == csra_pkg::EC_OK)
		else $error("commit reported with a non-receiving status");

	a_no_applied: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> res_s2.link != csra_pkg::LS_APPLIED)
		else $error("applied link state produced");

	a_att_err: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && res_s2.att != csra_pkg::ATT_OK |-> res_s2.link == csra_pkg::LS_ERROR)
		else $error("failing transfer without error state");

	a_code_link: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> (res_s2.code == csra_pkg::EC_OK) == (res_s2.link != csra_pkg::LS_ERROR))
		else $error("error code and link state disagree");

	a_read_att: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && res_s2.rd_sel |-> res_s2.att == csra_pkg::ATT_OK && !res_s2.commit)
		else $error("read result carries write status");

endmodule

>>> rtl/csra_store.sv
`timescale 1ns / 1ps

module csra_store #(
	parameter int DEPTH = csra_pkg::MAX_MESSAGE_BYTES_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/csra_ctrl.sv
`timescale 1ns / 1ps

module csra_ctrl #(
	parameter int MAX_BYTES = csra_pkg::MAX_MESSAGE_BYTES_DEF,
	localparam int AW       = $clog2(MAX_BYTES),
	localparam int LEN_W    = $clog2(MAX_BYTES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                fire,
	input  csra_pkg::func_t     func,
	input  logic [7:0]          data_byte,
	input  logic                end_of_write,
	input  logic [9:0]          read_index,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [7:0]          mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	output csra_pkg::res_t      res
);

	localparam int CMP_W = (LEN_W > 10) ? LEN_W : 10;

	logic [7:0]           first_mask_q, last_mask_q, abort_mask_q;
	logic [7:0]           hseq_q, hflags_q, hlen_q;
	logic [7:0]           hseq_n, hflags_n, hlen_n;
	logic [7:0]           exp_q, exp_n;
	logic [8:0]           wbc_q, wbc_n;
	logic [LEN_W-1:0]     fill_q, fill_n;
	logic [LEN_W-1:0]     comm_q, comm_n;
	csra_pkg::link_t      link_q, link_n;
	csra_pkg::err_t       code_q, code_n;

	logic [8:0]           offset;
	logic [LEN_W:0]       pos;
	logic                 pw_ok;
	logic [CMP_W-1:0]     ridx_x, comm_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_mask_q <= csra_pkg::FIRST_MASK_RST;
			last_mask_q  <= csra_pkg::LAST_MASK_RST;
			abort_mask_q <= csra_pkg::ABORT_MASK_RST;
		end else if (cfg_we) begin
			unique case (csra_pkg::cfg_idx_t'(cfg_index))
				csra_pkg::CFG_FIRST_MASK: first_mask_q <= cfg_wdata;
				csra_pkg::CFG_LAST_MASK:  last_mask_q  <= cfg_wdata;
				csra_pkg::CFG_ABORT_MASK: abort_mask_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// payload bytes land in the store as they arrive
	assign offset = wbc_q - 9'(csra_pkg::HEADER_BYTES);
	always_comb begin
		logic pw_first, pw_abort, pw_cont;
		pw_first = (hflags_q & first_mask_q) != 8'd0;
		pw_abort = (hflags_q & abort_mask_q) != 8'd0;
		pw_cont  = (fill_q != '0) && (hseq_q == 8'(exp_q + 8'd1));
		pos      = (pw_first ? '0 : (LEN_W+1)'(fill_q)) + (LEN_W+1)'(offset);
		pw_ok    = !pw_abort && (offset < {1'b0, hlen_q}) && (pw_first || pw_cont)
			&& (pos < (LEN_W+1)'(MAX_BYTES));
	end

	assign mem_waddr = pos[AW-1:0];
	assign mem_wdata = data_byte;
	assign ridx_x    = CMP_W'(read_index);
	assign comm_x    = CMP_W'(comm_q);
	assign mem_raddr = ridx_x[AW-1:0];

	always_comb begin
		logic             f_first, f_last, f_abort, f_bad;
		logic [9:0]       total;
		logic [LEN_W:0]   grown;

		hseq_n   = hseq_q;
		hflags_n = hflags_q;
		hlen_n   = hlen_q;
		wbc_n    = wbc_q;
		fill_n   = fill_q;
		exp_n    = exp_q;
		comm_n   = comm_q;
		link_n   = link_q;
		code_n   = code_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		res.has_result = 1'b0;
		res.att        = csra_pkg::ATT_OK;
		res.commit     = 1'b0;
		res.rd_sel     = 1'b0;

		if (fire && func == csra_pkg::FN_WRITE) begin
			if (wbc_q == 9'd0) begin
				hseq_n = data_byte;
			end else if (wbc_q == 9'd1) begin
				hflags_n = data_byte;
			end else if (wbc_q == 9'd2) begin
				hlen_n = data_byte;
			end
		end
		f_first = (hflags_n & first_mask_q) != 8'd0;
		f_last  = (hflags_n & last_mask_q) != 8'd0;
		f_abort = (hflags_n & abort_mask_q) != 8'd0;
		total   = {1'b0, wbc_q} + 10'd1;
		f_bad   = (total < 10'(csra_pkg::HEADER_BYTES))
			|| (total != 10'(csra_pkg::HEADER_BYTES) + {2'b00, hlen_n});
		grown   = (f_first ? '0 : (LEN_W+1)'(fill_q)) + (LEN_W+1)'(hlen_n);

		if (fire) begin
			unique case (func)
				csra_pkg::FN_WRITE: begin
					if (wbc_q >= 9'(csra_pkg::HEADER_BYTES)) begin
						mem_we = pw_ok;
					end
					if (!end_of_write) begin
						wbc_n = (wbc_q == csra_pkg::COUNT_MAX) ? csra_pkg::COUNT_MAX
							: wbc_q + 9'd1;
					end else begin
						wbc_n = '0;
						res.has_result = 1'b1;
						if (f_bad) begin
							link_n  = csra_pkg::LS_ERROR;
							code_n  = csra_pkg::EC_BAD_FRAME;
							res.att = csra_pkg::ATT_BAD_LEN;
						end else if (f_abort) begin
							fill_n = '0;
							exp_n  = '0;
							link_n = csra_pkg::LS_IDLE;
							code_n = csra_pkg::EC_OK;
						end else if (!f_first && hseq_n != 8'(exp_q + 8'd1)) begin
							fill_n  = '0;
							exp_n   = '0;
							link_n  = csra_pkg::LS_ERROR;
							code_n  = csra_pkg::EC_SEQ_GAP;
							res.att = csra_pkg::ATT_UNLIKELY;
						end else if (!f_first && fill_q == '0) begin
							exp_n   = hseq_n;
							link_n  = csra_pkg::LS_ERROR;
							code_n  = csra_pkg::EC_NO_FIRST;
							res.att = csra_pkg::ATT_UNLIKELY;
						end else if (grown > (LEN_W+1)'(MAX_BYTES)) begin
							fill_n  = '0;
							exp_n   = '0;
							link_n  = csra_pkg::LS_ERROR;
							code_n  = csra_pkg::EC_TOO_LONG;
							res.att = csra_pkg::ATT_NO_RES;
						end else begin
							link_n = csra_pkg::LS_RECEIVING;
							code_n = csra_pkg::EC_OK;
							if (f_last) begin
								comm_n     = grown[LEN_W-1:0];
								fill_n     = '0;
								exp_n      = '0;
								res.commit = 1'b1;
							end else begin
								fill_n = grown[LEN_W-1:0];
								exp_n  = hseq_n;
							end
						end
					end
				end
				csra_pkg::FN_READ: begin
					mem_re         = 1'b1;
					res.has_result = 1'b1;
					res.rd_sel     = ridx_x < comm_x;
				end
				csra_pkg::FN_ABORT: begin
					fill_n = '0;
					exp_n  = '0;
					link_n = csra_pkg::LS_IDLE;
					code_n = csra_pkg::EC_OK;
					res.has_result = 1'b1;
				end
				default: ;
			endcase
		end

		res.msg_len  = 11'(comm_n);
		res.fill_cnt = fill_n[7:0];
		res.link     = link_n;
		res.code     = code_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hseq_q   <= '0;
			hflags_q <= '0;
			hlen_q   <= '0;
			wbc_q    <= '0;
			fill_q   <= '0;
			exp_q    <= '0;
			comm_q   <= '0;
			link_q   <= csra_pkg::LS_IDLE;
			code_q   <= csra_pkg::EC_OK;
		end else begin
			hseq_q   <= hseq_n;
			hflags_q <= hflags_n;
			hlen_q   <= hlen_n;
			wbc_q    <= wbc_n;
			fill_q   <= fill_n;
			exp_q    <= exp_n;
			comm_q   <= comm_n;
			link_q   <= link_n;
			code_q   <= code_n;
		end
	end

endmodule
